// ===== hdl/lsdrs_pkg.sv =====
// Shared types and constants for the key/value sorting chain.
`timescale 1ns / 1ps
package lsdrs_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned PayW = 64;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
  } pair_t;

  // Commands that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== hdl/lsd_radix_sort_key_value_core.sv =====
// Top level of the key/value sorter: input control, sorting chain and result register.
`timescale 1ns / 1ps
// The block collects up to CAPACITY key/value pairs, one per input beat, and
// keeps them in ascending order of the low KEY_BITS bits of the key at all
// times: every pair is slotted into a row of CAPACITY cells in the cycle it is
// taken, behind any pairs with an equal key, so the order is stable. A beat
// with batch_end_i set closes the batch; the input is then stalled while the
// chain shifts its contents out towards the result register, one result beat
// per cycle while the output is not stalled, the last marked by final_item_o.
// Both loading and emptying go through the shift of the cell row. Pairs
// arriving while the chain is full are dropped and overflowed_o is raised on
// every result beat of that batch. The pair count and overflow flag clear
// once the final beat has left the chain, and the next batch may load while
// that final result still waits in the output register.
module lsd_radix_sort_key_value_core #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] sort_key_i,
  input  logic [63:0] payload_i,
  input  logic        batch_end_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] sorted_key_o,
  output logic [63:0] sorted_payload_o,
  output logic        final_item_o,
  output logic        overflowed_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Batch control.
  logic            draining_q, draining_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  // Result register.
  logic             out_vld_q, out_vld_d;
  lsdrs_pkg::pair_t out_pair_q, out_pair_d;
  logic             out_final_q, out_final_d;
  logic             out_ovf_q, out_ovf_d;

  logic                   in_beat;
  logic                   room;
  logic                   last_pop;
  lsdrs_pkg::cell_ctrl_t  ctrl;
  lsdrs_pkg::pair_t       new_pair;

  // Cell outputs, one entry per place in the chain.
  lsdrs_pkg::pair_t [CAPACITY-1:0] cell_pair;
  logic [CAPACITY-1:0]             cell_vld;
  logic [CAPACITY-1:0]             cell_before;

  assign stall_o  = draining_q;
  assign in_beat  = valid_i && !draining_q;
  assign room     = (count_q != CntW'(CAPACITY));
  assign new_pair = '{key: sort_key_i, payload: payload_i};

  // The chain only moves towards the result register while that register is
  // empty or its beat is being taken in this cycle.
  assign ctrl.pop    = draining_q && (!out_vld_q || !stall_i);
  assign ctrl.insert = in_beat && room;
  assign last_pop    = ctrl.pop && (count_q == CntW'(1));

  // Row of cells: each sees its upstream neighbour for an insertion shift and
  // its downstream neighbour for the emptying shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lsdrs_pkg::pair_t prev_pair, next_pair;
    logic             prev_vld, prev_before, next_vld;

    if (i == 0) begin : g_head
      assign prev_pair   = new_pair;
      assign prev_vld    = 1'b0;
      assign prev_before = 1'b0;
    end else begin : g_body
      assign prev_pair   = cell_pair[i-1];
      assign prev_vld    = cell_vld[i-1];
      assign prev_before = cell_before[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_pair = new_pair;
      assign next_vld  = 1'b0;
    end else begin : g_inner
      assign next_pair = cell_pair[i+1];
      assign next_vld  = cell_vld[i+1];
    end

    lsdrs_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_pair_i    (new_pair),
      .prev_pair_i   (prev_pair),
      .prev_vld_i    (prev_vld),
      .prev_before_i (prev_before),
      .next_pair_i   (next_pair),
      .next_vld_i    (next_vld),
      .pair_o        (cell_pair[i]),
      .vld_o         (cell_vld[i]),
      .before_o      (cell_before[i])
    );
  end

  // Batch bookkeeping: a dropped pair sets the overflow flag, and a closing
  // beat switches over to emptying the chain.
  always_comb begin
    draining_d = draining_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    if (in_beat) begin
      if (room) begin
        count_d = count_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (batch_end_i) begin
        draining_d = 1'b1;
      end
    end
    if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
      if (last_pop) begin
        draining_d = 1'b0;
        ovf_d      = 1'b0;
      end
    end
  end

  always_comb begin
    out_vld_d   = out_vld_q;
    out_pair_d  = out_pair_q;
    out_final_d = out_final_q;
    out_ovf_d   = out_ovf_q;
    priority if (ctrl.pop) begin
      out_vld_d   = 1'b1;
      out_pair_d  = cell_pair[0];
      out_final_d = last_pop;
      out_ovf_d   = ovf_q;
    end else if (out_vld_q && !stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      draining_q <= draining_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pair_q  <= out_pair_d;
    out_final_q <= out_final_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign valid_o          = out_vld_q;
  assign sorted_key_o     = out_pair_q.key;
  assign sorted_payload_o = out_pair_q.payload;
  assign final_item_o     = out_final_q;
  assign overflowed_o     = out_ovf_q;

  // The occupied cells always form an unbroken run from the head of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, cell_vld} + {{CAPACITY{1'b0}}, 1'b1}))
    else $error("occupied cells are not a contiguous run from the head");

  // The pair count agrees with the number of occupied cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == 32'(count_q))
    else $error("pair count does not match occupied cells");

  // While emptying, the chain is never without a pair to hand on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> (count_q != '0))
    else $error("emptying with no pairs held");

  // Handing on the last pair ends the batch and leaves the overflow flag clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_pop |=> (!draining_q && !ovf_q && out_vld_q && final_item_o))
    else $error("batch did not close after its final pair");

endmodule

// ===== hdl/lsdrs_cell.sv =====
// One cell of the sorting chain: holds one pair and its valid flag.
`timescale 1ns / 1ps
module lsdrs_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsdrs_pkg::cell_ctrl_t ctrl_i,
  input  lsdrs_pkg::pair_t    new_pair_i,
  input  lsdrs_pkg::pair_t    prev_pair_i,
  input  logic                prev_vld_i,
  input  logic                prev_before_i,
  input  lsdrs_pkg::pair_t    next_pair_i,
  input  logic                next_vld_i,
  output lsdrs_pkg::pair_t    pair_o,
  output logic                vld_o,
  output logic                before_o
);

  lsdrs_pkg::pair_t pair_q, pair_d;
  logic             vld_q, vld_d;

  // The new pair belongs at or ahead of this place when the cell is empty or
  // holds a strictly larger key; equal keys keep their arrival order.
  assign before_o = !vld_q ||
                    (new_pair_i.key[KEY_BITS-1:0] < pair_q.key[KEY_BITS-1:0]);

  always_comb begin
    priority if (ctrl_i.pop) begin
      pair_d = next_pair_i;
      vld_d  = next_vld_i;
    end else if (ctrl_i.insert && prev_before_i) begin
      pair_d = prev_pair_i;
      vld_d  = prev_vld_i;
    end else if (ctrl_i.insert && before_o) begin
      pair_d = new_pair_i;
      vld_d  = 1'b1;
    end else begin
      pair_d = pair_q;
      vld_d  = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign pair_o = pair_q;
  assign vld_o  = vld_q;

endmodule

// ===== test/sorted_pair_checker.sv =====
// Scoreboard for the key/value sorter: predicts each sorted batch and checks every result beat.
`timescale 1ns / 1ps
module sorted_pair_checker #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_valid_i,
  input  logic        load_stall_i,
  input  logic [63:0] load_key_i,
  input  logic [63:0] load_payload_i,
  input  logic        load_last_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [63:0] res_key_i,
  input  logic [63:0] res_payload_i,
  input  logic        res_final_i,
  input  logic        res_overflow_i,
  output int          error_count_o,
  output int          awaited_beats_o
);

  typedef struct packed {
    lsdrs_pkg::pair_t pair;
    logic             final_item;
    logic             overflowed;
  } sorted_beat_t;

  // Only the low KEY_BITS bits of a key decide the order.
  localparam logic [63:0] OrderMask =
      (KEY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

  lsdrs_pkg::pair_t batch_q[$];
  logic             batch_dropped = 1'b0;
  sorted_beat_t     awaited_q[$];
  int               errors = 0;
  int               awaited = 0;

  assign error_count_o   = errors;
  assign awaited_beats_o = awaited;

  // Stable ascending order of the held batch; the result beats are queued in that order.
  function automatic void close_batch();
    lsdrs_pkg::pair_t order[$];
    lsdrs_pkg::pair_t moving;
    sorted_beat_t     beat;
    int               j;
    order = batch_q;
    for (int i = 1; i < order.size(); i++) begin
      moving = order[i];
      j = i - 1;
      while (j >= 0 && (order[j].key & OrderMask) > (moving.key & OrderMask)) begin
        order[j+1] = order[j];
        j--;
      end
      order[j+1] = moving;
    end
    for (int i = 0; i < order.size(); i++) begin
      beat.pair       = order[i];
      beat.final_item = (i == order.size() - 1);
      beat.overflowed = batch_dropped;
      awaited_q.push_back(beat);
    end
    batch_q.delete();
    batch_dropped = 1'b0;
  endfunction

  always @(posedge clk_i) begin : watch
    sorted_beat_t want;
    if (rst_ni) begin
      // Results first: a beat leaving in the cycle a batch closes cannot belong to it.
      if (res_valid_i && !res_stall_i) begin
        if (awaited_q.size() == 0) begin
          $error("result beat with no result awaited: key %h payload %h",
                 res_key_i, res_payload_i);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          if (res_key_i !== want.pair.key) begin
            $error("sorted_key: expected %h, got %h", want.pair.key, res_key_i);
            errors++;
          end
          if (res_payload_i !== want.pair.payload) begin
            $error("sorted_payload: expected %h, got %h", want.pair.payload, res_payload_i);
            errors++;
          end
          if (res_final_i !== want.final_item) begin
            $error("final_item: expected %b, got %b", want.final_item, res_final_i);
            errors++;
          end
          if (res_overflow_i !== want.overflowed) begin
            $error("overflowed: expected %b, got %b", want.overflowed, res_overflow_i);
            errors++;
          end
        end
      end
      if (load_valid_i && !load_stall_i) begin
        if (batch_q.size() < CAPACITY) begin
          batch_q.push_back({load_key_i, load_payload_i});
        end else begin
          batch_dropped = 1'b1;
        end
        if (load_last_i) begin
          close_batch();
        end
      end
    end
    awaited = awaited_q.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the sorter testbench: clock, reset, stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;

  // The block is built with its default sizes; the checker is told the same.
  localparam int unsigned Capacity   = 64;
  localparam int unsigned KeyBits    = 64;
  // Pairs to send in all, and the point at which the overflow batch goes in.
  localparam int          RandomTarget  = 130;
  localparam int          OverflowPoint = 50;
  // How long to keep watching the output for stray beats once none is awaited.
  localparam int          DrainCycles   = 150;
  localparam int          CycleLimit    = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [63:0] sort_key_i;
  logic [63:0] payload_i;
  logic        batch_end_i;
  logic        valid_o;
  logic        stall_i;
  logic [63:0] sorted_key_o;
  logic [63:0] sorted_payload_o;
  logic        final_item_o;
  logic        overflowed_o;

  int   error_count;
  int   awaited_beats;
  int   cycle_count = 0;
  int   pairs_sent = 0;
  // When set, the side concerned runs without gaps for a while.
  logic steady_load = 1'b0;
  logic steady_drain = 1'b0;

  lsd_radix_sort_key_value_core #(
    .CAPACITY(Capacity),
    .KEY_BITS(KeyBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .sort_key_i      (sort_key_i),
    .payload_i       (payload_i),
    .batch_end_i     (batch_end_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .sorted_key_o    (sorted_key_o),
    .sorted_payload_o(sorted_payload_o),
    .final_item_o    (final_item_o),
    .overflowed_o    (overflowed_o)
  );

  sorted_pair_checker #(
    .CAPACITY(Capacity),
    .KEY_BITS(KeyBits)
  ) checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_valid_i   (valid_i),
    .load_stall_i   (stall_o),
    .load_key_i     (sort_key_i),
    .load_payload_i (payload_i),
    .load_last_i    (batch_end_i),
    .res_valid_i    (valid_o),
    .res_stall_i    (stall_i),
    .res_key_i      (sorted_key_o),
    .res_payload_i  (sorted_payload_o),
    .res_final_i    (final_item_o),
    .res_overflow_i (overflowed_o),
    .error_count_o  (error_count),
    .awaited_beats_o(awaited_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A hung handshake would otherwise leave the run going for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Output back-pressure: before each result beat the receiver holds stall for a drawn
  // number of cycles, then lowers it and waits for the beat to be taken. Now and then it
  // flips into a steady phase in which it never stalls.
  initial begin
    int hold;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 15) == 0) begin
        steady_drain = !steady_drain;
      end
      hold = steady_drain ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
    end
  end

  // Presents one pair after a drawn gap and returns at the edge that takes it. Valid is
  // left high, so back-to-back beats need no extra assignment at the falling edge.
  task automatic send_pair(input logic [63:0] key, input logic [63:0] pay, input logic last);
    int gap;
    gap = steady_load ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      valid_i <= 1'b0;
    end
    @(negedge clk_i);
    valid_i     <= 1'b1;
    sort_key_i  <= key;
    payload_i   <= pay;
    batch_end_i <= last;
    do @(posedge clk_i); while (stall_o);
    pairs_sent++;
  endtask

  // Keys are drawn so that duplicates, extremes and keys that differ only in their high
  // digits all turn up often; a fully random key on its own would almost never tie.
  function automatic logic [63:0] pick_key();
    logic [63:0] key;
    case ($urandom_range(0, 3))
      0: key = 64'($urandom_range(0, 7));
      1: key = {$urandom, $urandom};
      2: key = {$urandom, 28'h0, 4'($urandom_range(0, 3))};
      default: begin
        case ($urandom_range(0, 2))
          0: key = '0;
          1: key = '1;
          default: key = 64'd1 << $urandom_range(0, 63);
        endcase
      end
    endcase
    return key;
  endfunction

  task automatic send_random_batch(input int n);
    steady_load = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      send_pair(pick_key(), {$urandom, $urandom}, i == n - 1);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    valid_i     = 1'b0;
    sort_key_i  = '0;
    payload_i   = '0;
    batch_end_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // One-pair batches must come straight through, marked as the final beat.
    send_pair('1, '0, 1'b1);
    send_pair('0, '1, 1'b1);

    // Extremes and ties: the two zero keys and the two all-ones keys must keep the
    // order in which they arrived.
    send_pair('1, 64'd1, 1'b0);
    send_pair('0, 64'd2, 1'b0);
    send_pair(64'h8000_0000_0000_0000, 64'd3, 1'b0);
    send_pair('0, 64'd4, 1'b0);
    send_pair(64'd1, 64'd5, 1'b0);
    send_pair('1, 64'd6, 1'b1);

    // Keys alike in their low digits, so only the top digit decides.
    send_pair(64'hF000_0000_0000_0005, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_pair(64'h0000_0000_0000_0005, 64'h5555_5555_5555_5555, 1'b0);
    send_pair(64'h7000_0000_0000_0005, 64'hFFFF_0000_FFFF_0000, 1'b1);

    // Digit patterns running against each other in every position.
    send_pair(64'h0123_4567_89AB_CDEF, 64'h5555_5555_5555_5555, 1'b0);
    send_pair(64'hFEDC_BA98_7654_3210, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_pair(64'h0F0F_0F0F_0F0F_0F0F, 64'h0000_FFFF_0000_FFFF, 1'b0);
    send_pair(64'hF0F0_F0F0_F0F0_F0F0, 64'h0123_4567_89AB_CDEF, 1'b1);

    // Random part: mostly short batches, with one batch that runs past the capacity.
    // Its closing pair is itself dropped, yet it must still start the output.
    while (pairs_sent < OverflowPoint) begin
      send_random_batch($urandom_range(1, 8));
    end
    send_random_batch($urandom_range(Capacity + 1, Capacity + 4));

    // Hold the input off until the whole overflowed batch has come out.
    @(negedge clk_i);
    valid_i <= 1'b0;
    wait (awaited_beats == 0);

    while (pairs_sent < RandomTarget) begin
      send_random_batch($urandom_range(1, 8));
    end

    @(negedge clk_i);
    valid_i <= 1'b0;
    wait (awaited_beats == 0);
    // Anything the block emits after the last awaited beat is caught by the checker here.
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && awaited_beats == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lsdrs_pkg.sv
hdl/lsdrs_cell.sv
hdl/lsd_radix_sort_key_value_core.sv
test/sorted_pair_checker.sv
test/testbench.sv
